// File: hw/rtl/trle_pkg.sv
// Shared types and constants for the run-length pixel decoder.
// No dependencies; used by trle_core, trle_outbuf and tga_rle_pixel_decoder.
package trle_pkg;

  // Field and register widths
  localparam int unsigned IDX_W   = 22;
  localparam int unsigned TOTAL_W = 23;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned CFG_W   = 23;
  localparam int unsigned CFG_IDX_W = 2;

  // Largest image supported, in pixels
  localparam logic [TOTAL_W-1:0] MAX_PIXELS = 23'd4194304;

  // Reset values of the configuration registers
  localparam logic                 RST_COMPRESSED = 1'b1;
  localparam logic [BPP_W-1:0]     RST_BPP        = 3'd3;
  localparam logic [TOTAL_W-1:0]   RST_TOTAL      = 23'd65536;

  // Packet header decoding
  localparam logic [CNT_W-1:0] RUN_BIAS = 8'd127;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMPRESSED = 2'd0,
    CFG_BPP        = 2'd1,
    CFG_TOTAL      = 2'd2
  } cfg_idx_t;

  // One fill command
  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [VAL_W-1:0] pixel_value;
    logic [CNT_W-1:0] repeat_count;
    logic             image_done;
  } fill_cmd_t;

endpackage

// File: hw/rtl/trle_core.sv
// Decoder state and per-byte decode logic: configuration registers, packet
// tracking, pixel assembly and index counter. Depends on trle_pkg.
module trle_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [trle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trle_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               byte_take,
  input  logic [7:0]                         data_byte,
  output logic                               cmd_push,
  output trle_pkg::fill_cmd_t                cmd_data
);

  // Configuration registers
  logic                              compressed_r;
  logic [trle_pkg::BPP_W-1:0]        bpp_r;
  logic [trle_pkg::TOTAL_W-1:0]      pixel_total_r;

  // Decoder state
  logic                              awaiting_hdr_r, awaiting_hdr_nxt;
  logic                              pkt_run_r, pkt_run_nxt;
  logic [trle_pkg::CNT_W-1:0]        pkt_left_r, pkt_left_nxt;
  logic [1:0]                        byte_pos_r, byte_pos_nxt;
  logic [trle_pkg::VAL_W-1:0]        asm_r, asm_nxt;
  logic [trle_pkg::IDX_W-1:0]        next_pix_r, next_pix_nxt;

  // Intermediate values
  logic [trle_pkg::TOTAL_W-1:0]      total;
  logic [trle_pkg::IDX_W-1:0]        np_eff;
  logic [trle_pkg::TOTAL_W-1:0]      left;
  logic [trle_pkg::BPP_W-1:0]        bpp;
  logic                              complete;
  logic [trle_pkg::CNT_W-1:0]        hdr_cnt, hdr_clamp;
  logic [trle_pkg::CNT_W-1:0]        pkt_cnt, pkt_clamp;
  logic [trle_pkg::CNT_W-1:0]        emit_cnt;
  logic [trle_pkg::TOTAL_W-1:0]      sum;
  logic                              done;
  logic                              emit;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compressed_r  <= trle_pkg::RST_COMPRESSED;
      bpp_r         <= trle_pkg::RST_BPP;
      pixel_total_r <= trle_pkg::RST_TOTAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        trle_pkg::CFG_COMPRESSED: compressed_r  <= cfg_wdata[0];
        trle_pkg::CFG_BPP:        bpp_r         <= cfg_wdata[trle_pkg::BPP_W-1:0];
        trle_pkg::CFG_TOTAL:      pixel_total_r <= cfg_wdata[trle_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective image size, pixel size and restarted index
  always_comb begin
    if (pixel_total_r == '0) begin
      total = trle_pkg::TOTAL_W'(1);
    end else if (pixel_total_r > trle_pkg::MAX_PIXELS) begin
      total = trle_pkg::MAX_PIXELS;
    end else begin
      total = pixel_total_r;
    end
    if (bpp_r == '0) begin
      bpp = 3'd1;
    end else if (bpp_r > 3'd4) begin
      bpp = 3'd4;
    end else begin
      bpp = bpp_r;
    end
  end

  assign np_eff = ({1'b0, next_pix_r} >= total) ? '0 : next_pix_r;
  assign left   = total - {1'b0, np_eff};

  // Pixel assembly: the first byte of a pixel clears the word.
  always_comb begin
    asm_nxt = (byte_pos_r == 2'd0) ? '0 : asm_r;
    asm_nxt = asm_nxt | ({24'd0, data_byte} << {byte_pos_r, 3'b000});
  end
  assign complete = (({1'b0, byte_pos_r}) + 3'd1) >= bpp;

  // Packet lengths, each clamped to the pixels left in the image
  assign hdr_cnt   = data_byte[7] ? (data_byte - trle_pkg::RUN_BIAS) : (data_byte + 8'd1);
  assign hdr_clamp = ({15'd0, hdr_cnt} > left) ? left[trle_pkg::CNT_W-1:0] : hdr_cnt;
  assign pkt_cnt   = (pkt_left_r == '0) ? 8'd1 : pkt_left_r;
  assign pkt_clamp = ({15'd0, pkt_cnt} > left) ? left[trle_pkg::CNT_W-1:0] : pkt_cnt;

  // Fill command length and end-of-image detection
  assign emit_cnt = (compressed_r && pkt_run_r) ? pkt_clamp : 8'd1;
  assign sum      = {1'b0, np_eff} + {15'd0, emit_cnt};
  assign done     = sum >= total;

  // Next state for an accepted byte
  always_comb begin
    awaiting_hdr_nxt = awaiting_hdr_r;
    pkt_run_nxt      = pkt_run_r;
    pkt_left_nxt     = pkt_left_r;
    byte_pos_nxt     = complete ? 2'd0 : (byte_pos_r + 2'd1);
    next_pix_nxt     = np_eff;
    emit             = 1'b0;
    if (!compressed_r) begin
      emit = complete;
    end else if (awaiting_hdr_r) begin
      pkt_run_nxt      = data_byte[7];
      pkt_left_nxt     = hdr_clamp;
      byte_pos_nxt     = 2'd0;
      awaiting_hdr_nxt = 1'b0;
    end else if (complete) begin
      emit = 1'b1;
      if (pkt_run_r) begin
        pkt_left_nxt     = '0;
        awaiting_hdr_nxt = 1'b1;
      end else begin
        pkt_left_nxt = pkt_clamp - 8'd1;
        if ((pkt_clamp == 8'd1) || done) begin
          pkt_left_nxt     = '0;
          awaiting_hdr_nxt = 1'b1;
        end
      end
    end
    if (emit) begin
      next_pix_nxt = done ? '0 : sum[trle_pkg::IDX_W-1:0];
    end
  end

  // State registers, updated on each byte transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_hdr_r <= 1'b1;
      pkt_run_r      <= 1'b0;
      pkt_left_r     <= '0;
      byte_pos_r     <= '0;
      asm_r          <= '0;
      next_pix_r     <= '0;
    end else if (byte_take) begin
      awaiting_hdr_r <= awaiting_hdr_nxt;
      pkt_run_r      <= pkt_run_nxt;
      pkt_left_r     <= pkt_left_nxt;
      byte_pos_r     <= byte_pos_nxt;
      next_pix_r     <= next_pix_nxt;
      if (!(compressed_r && awaiting_hdr_r)) begin
        asm_r <= asm_nxt;
      end
    end
  end

  // Fill command towards the output stage
  assign cmd_push              = byte_take && emit;
  assign cmd_data.pixel_index  = np_eff;
  assign cmd_data.pixel_value  = asm_nxt;
  assign cmd_data.repeat_count = emit_cnt;
  assign cmd_data.image_done   = done;

`ifndef SYNTHESIS
  // An open packet always has at least one pixel to go.
  a_open_pkt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !awaiting_hdr_r |-> (pkt_left_r != '0))
    else $error("open packet with no pixels left");

  // A header byte never produces a fill command.
  a_hdr_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_take && compressed_r && awaiting_hdr_r) |-> !cmd_push)
    else $error("header byte produced a fill command");

  // A run command never reaches past the end of the image.
  a_cmd_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> (sum <= total))
    else $error("fill command runs past the image end");
`endif

endmodule

// File: hw/rtl/trle_outbuf.sv
// Output register with one skid entry for fill commands, so the decoder
// keeps taking bytes while a result waits. Depends on trle_pkg.
module trle_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  trle_pkg::fill_cmd_t  push_data,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output trle_pkg::fill_cmd_t  out_data
);

  logic                 main_v_r, main_v_nxt;
  logic                 skid_v_r, skid_v_nxt;
  trle_pkg::fill_cmd_t  main_d_r, main_d_nxt;
  trle_pkg::fill_cmd_t  skid_d_r, skid_d_nxt;
  logic                 pop;

  assign pop = main_v_r && out_ready;

  // Refill the output register from the skid entry first, then from the core.
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_v_nxt = 1'b1;
        main_d_nxt = skid_d_r;
        skid_v_nxt = push;
        if (push) begin
          skid_d_nxt = push_data;
        end
      end else begin
        main_v_nxt = push;
        if (push) begin
          main_d_nxt = push_data;
        end
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

`ifndef SYNTHESIS
  // The skid entry is only occupied behind a waiting output.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry full while output empty");

  // A stalled output with a full skid entry keeps both entries.
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_ready) |=> (skid_v_r && main_v_r))
    else $error("command lost during stall");

  // No command is pushed into a full buffer.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_v_r)
    else $error("push into full output buffer");
`endif

endmodule

// File: hw/rtl/tga_rle_pixel_decoder.sv
// Top level of the run-length pixel decoder: byte input channel, fill
// command output channel and register write port. Depends on trle_pkg,
// trle_core and trle_outbuf.
//
// Usage:
//   Pixel-data bytes enter on the in_ channel (valid/ready), one per transfer.
//   Fill commands leave on the out_ channel: first pixel index, packed pixel
//   value, repeat count and an end-of-image flag. Header bytes and bytes
//   that do not finish a pixel give no command.
//   Registers (compression on/off, bytes per pixel, pixels per image) are
//   written through cfg_we/cfg_index/cfg_wdata while the stream is idle.
//   Throughput: one byte per clock cycle while in_ready is high; every byte
//   is decoded by the decode logic between the state registers and the
//   output register.
//   A command is written into the output register, or the skid entry while
//   the output is stalled, on the transfer of the byte that completes it.
//   Stall: the output register has one skid entry behind it; in_ready drops
//   only when both hold a command, and no command is lost or repeated.
//   Reset (rst_n low, synchronous) empties the output stage, returns the
//   registers to run-length mode, 3 bytes per pixel, 65536 pixels, and
//   expects a packet header at pixel index zero.
module tga_rle_pixel_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [trle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trle_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [trle_pkg::IDX_W-1:0]        out_pixel_index,
  output logic [trle_pkg::VAL_W-1:0]        out_pixel_value,
  output logic [trle_pkg::CNT_W-1:0]        out_repeat_count,
  output logic                              out_image_done
);

  logic                 byte_take;
  logic                 cmd_push;
  logic                 space;
  trle_pkg::fill_cmd_t  cmd_data;
  trle_pkg::fill_cmd_t  out_data;

  assign in_ready  = space;
  assign byte_take = in_valid && in_ready;

  // Per-byte decoding and state
  trle_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .byte_take (byte_take),
    .data_byte (in_data_byte),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_data)
  );

  // Output register and skid entry
  trle_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_data),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_pixel_index  = out_data.pixel_index;
  assign out_pixel_value  = out_data.pixel_value;
  assign out_repeat_count = out_data.repeat_count;
  assign out_image_done   = out_data.image_done;

`ifndef SYNTHESIS
  // Every command fills at least one pixel.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_repeat_count != '0))
    else $error("fill command with zero repeat count");

  // A command that ends the image is followed by one starting at index zero.
  a_wrap_to_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_image_done && cmd_push) |->
      (cmd_data.pixel_index == '0))
    else $error("index did not restart after image end");

  // A byte transfer is refused only while the output is stalled.
  a_ready_when_draining: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && $past(out_valid)))
    else $error("input stalled without a waiting command");
`endif

endmodule

// File: bench/trle_fill_checker.sv
// Checker for the run-length pixel decoder: follows register writes and byte
// transfers, predicts every fill command and compares it with the out_ channel.
// Depends on trle_pkg only.
module trle_fill_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [trle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trle_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [trle_pkg::IDX_W-1:0]     out_pixel_index,
  input  logic [trle_pkg::VAL_W-1:0]     out_pixel_value,
  input  logic [trle_pkg::CNT_W-1:0]     out_repeat_count,
  input  logic                           out_image_done,
  output int                             fail_count,
  output int                             fills_pending
);
  import trle_pkg::*;

  // Local copies of the configuration registers
  logic               rle_on;
  logic [BPP_W-1:0]   bpp_reg;
  logic [TOTAL_W-1:0] total_reg;

  // Decoder state as the predictor sees it
  logic               hdr_wait;
  logic               run_pkt;
  logic [CNT_W-1:0]   pkt_left;
  logic [1:0]         byte_pos;
  logic [VAL_W-1:0]   pix_acc;
  int                 next_idx;

  fill_cmd_t          fill_q[$];
  int                 errors;

  // Image size with out-of-range register values folded back into range.
  function automatic int image_pixels();
    int t;
    t = int'(total_reg);
    if (t > int'(MAX_PIXELS)) t = int'(MAX_PIXELS);
    if (t == 0) t = 1;
    return t;
  endfunction

  function automatic int pixel_bytes();
    int b;
    b = int'(bpp_reg);
    if (b == 0) b = 1;
    if (b > 4) b = 4;
    return b;
  endfunction

  // Packs one byte into the pixel under assembly; true once the pixel is whole.
  function automatic bit add_byte(input logic [7:0] b);
    int pos;
    pos = int'(byte_pos);
    if (pos == 0) pix_acc = '0;
    pix_acc = pix_acc | (VAL_W'(b) << (8 * pos));
    if (pos + 1 >= pixel_bytes()) begin
      byte_pos = '0;
      return 1'b1;
    end
    byte_pos = 2'(pos + 1);
    return 1'b0;
  endfunction

  // Queues one fill command of cnt pixels and moves the pixel index on.
  function automatic void queue_fill(input int cnt, input int img);
    fill_cmd_t cmd;
    bit        last;
    last             = (next_idx + cnt >= img);
    cmd.pixel_index  = IDX_W'(next_idx);
    cmd.pixel_value  = pix_acc;
    cmd.repeat_count = CNT_W'(cnt);
    cmd.image_done   = last;
    fill_q.push_back(cmd);
    next_idx = last ? 0 : next_idx + cnt;
  endfunction

  // Works out what one accepted byte does to the decoder.
  function automatic void decode_byte(input logic [7:0] b);
    int img;
    int room;
    int cnt;
    bit last;
    img = image_pixels();
    if (next_idx >= img) next_idx = 0;
    room = img - next_idx;
    if (!rle_on) begin
      // Raw data: every whole pixel is a single fill, packet state untouched
      if (add_byte(b)) queue_fill(1, img);
    end else if (hdr_wait) begin
      run_pkt  = b[7];
      cnt      = b[7] ? int'(b) - int'(RUN_BIAS) : int'(b) + 1;
      if (cnt > room) cnt = room;
      pkt_left = CNT_W'(cnt);
      byte_pos = '0;
      hdr_wait = 1'b0;
    end else if (add_byte(b)) begin
      cnt = int'(pkt_left);
      if (cnt == 0) cnt = 1;
      if (cnt > room) cnt = room;
      if (run_pkt) begin
        queue_fill(cnt, img);
        pkt_left = '0;
        hdr_wait = 1'b1;
      end else begin
        last = (next_idx + 1 >= img);
        queue_fill(1, img);
        pkt_left = CNT_W'(cnt - 1);
        if (pkt_left == 0 || last) begin
          pkt_left = '0;
          hdr_wait = 1'b1;
        end
      end
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Compares one fill command transfer with the oldest prediction.
  function automatic void check_fill();
    fill_cmd_t want;
    if (fill_q.size() == 0) begin
      errors++;
      $display("%0t: fill command with none expected, expected nothing, got %0h %0h %0h %0b",
               $time, out_pixel_index, out_pixel_value, out_repeat_count, out_image_done);
    end else begin
      want = fill_q.pop_front();
      compare_field("pixel_index", want.pixel_index, out_pixel_index);
      compare_field("pixel_value", want.pixel_value, out_pixel_value);
      compare_field("repeat_count", want.repeat_count, out_repeat_count);
      compare_field("image_done", want.image_done, out_image_done);
    end
  endfunction

  // Outputs are compared before the byte of the same edge is predicted, as a
  // command never leaves in the cycle of its own byte transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      rle_on    = RST_COMPRESSED;
      bpp_reg   = RST_BPP;
      total_reg = RST_TOTAL;
      hdr_wait  = 1'b1;
      run_pkt   = 1'b0;
      pkt_left  = '0;
      byte_pos  = '0;
      pix_acc   = '0;
      next_idx  = 0;
      errors    = 0;
      fill_q.delete();
    end else begin
      if (out_valid && out_ready) check_fill();
      if (cfg_we) begin
        case (cfg_index)
          CFG_COMPRESSED: rle_on    = cfg_wdata[0];
          CFG_BPP:        bpp_reg   = cfg_wdata[BPP_W-1:0];
          CFG_TOTAL:      total_reg = cfg_wdata[TOTAL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_byte(in_data_byte);
    end
    fail_count    <= errors;
    fills_pending <= fill_q.size();
  end

endmodule

// File: bench/tb.sv
// Top of the run-length pixel decoder testbench: clock, reset, byte stimulus,
// register writes, output back-pressure and the final verdict.
// Depends on trle_pkg, tga_rle_pixel_decoder and trle_fill_checker.
module tb;
  import trle_pkg::*;

  localparam int STALL_LIMIT       = 2000;
  localparam int HOLD_CYCLES       = 300;
  localparam int ITEMS_PER_SETTING = 86;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = CFG_COMPRESSED;
  logic [CFG_W-1:0]     cfg_wdata    = '0;
  logic                 in_valid     = 1'b0;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 out_ready    = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [IDX_W-1:0]     out_pixel_index;
  logic [VAL_W-1:0]     out_pixel_value;
  logic [CNT_W-1:0]     out_repeat_count;
  logic                 out_image_done;

  int fail_count;
  int fills_pending;
  int tx_idle_pct  = 26;
  int rx_idle_pct  = 64;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;
  int hold_cnt     = 0;
  int quiet_cycles = 0;

  // Stimulus-side view of the stream, used to keep packets well formed
  int bytes_sent = 0;
  bit rle_now    = 1'b1;
  int px_bytes   = 3;
  int img_pix    = 65536;
  int pix_pos    = 0;

  tga_rle_pixel_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_index  (out_pixel_index),
    .out_pixel_value  (out_pixel_value),
    .out_repeat_count (out_repeat_count),
    .out_image_done   (out_image_done)
  );

  trle_fill_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_index  (out_pixel_index),
    .out_pixel_value  (out_pixel_value),
    .out_repeat_count (out_repeat_count),
    .out_image_done   (out_image_done),
    .fail_count       (fail_count),
    .fills_pending    (fills_pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: random back-pressure, plus one long hold-off once requested.
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte, idling at random first, and waits for its transfer.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stops offering and waits until every predicted command has left the block.
  task automatic drain();
    in_valid <= 1'b0;
    repeat (3) @(posedge clk);
    while (fills_pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(input logic rle, input logic [BPP_W-1:0] bpp,
                              input logic [TOTAL_W-1:0] total);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COMPRESSED;
    cfg_wdata <= CFG_W'(rle);
    @(posedge clk);
    cfg_index <= CFG_BPP;
    cfg_wdata <= CFG_W'(bpp);
    @(posedge clk);
    cfg_index <= CFG_TOTAL;
    cfg_wdata <= CFG_W'(total);
    @(posedge clk);
    cfg_we   <= 1'b0;
    rle_now  = rle;
    px_bytes = (bpp == 0) ? 1 : (bpp > 4) ? 4 : int'(bpp);
    img_pix  = (total == 0) ? 1 : (total > MAX_PIXELS) ? int'(MAX_PIXELS) : int'(total);
    if (pix_pos >= img_pix) pix_pos = 0;
  endtask

  task automatic random_config();
    logic               rle;
    logic [BPP_W-1:0]   bpp;
    logic [TOTAL_W-1:0] total;
    rle = ($urandom_range(9) < 7);
    case ($urandom_range(9))
      0:       bpp = '0;
      1:       bpp = BPP_W'($urandom_range(7, 5));
      default: bpp = BPP_W'($urandom_range(4, 1));
    endcase
    case ($urandom_range(9))
      0:       total = TOTAL_W'(1);
      1:       total = MAX_PIXELS;
      2:       total = '1;
      3:       total = '0;
      4, 5:    total = TOTAL_W'($urandom_range(300, 2));
      default: total = TOTAL_W'($urandom_range(40, 2));
    endcase
    write_config(rle, bpp, total);
  endtask

  // Pixels a packet really covers once clamped at the end of the image.
  function automatic int clamp_pixels(input int want);
    return (want > img_pix - pix_pos) ? img_pix - pix_pos : want;
  endfunction

  function automatic void advance(input int n);
    pix_pos += n;
    if (pix_pos >= img_pix) pix_pos = 0;
  endfunction

  // One unit of random stimulus: mostly whole packets or pixels, some noise.
  task automatic send_unit();
    int roll;
    int hdr;
    int n;
    roll = $urandom_range(99);
    if (roll < 5) begin
      send_byte(8'($urandom_range(255)));
    end else if (!rle_now) begin
      repeat (px_bytes) send_byte(8'($urandom_range(255)));
      advance(1);
    end else if (roll < 50) begin
      hdr = $urandom_range(255, 128);
      send_byte(8'(hdr));
      repeat (px_bytes) send_byte(8'($urandom_range(255)));
      advance(clamp_pixels(hdr - int'(RUN_BIAS)));
    end else begin
      hdr = (roll < 53) ? $urandom_range(127) : $urandom_range(7);
      n   = clamp_pixels(hdr + 1);
      send_byte(8'(hdr));
      repeat (n * px_bytes) send_byte(8'($urandom_range(255)));
      advance(n);
    end
  endtask

  initial begin
    int goal;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults after reset: literal of one pixel, run of 128, then the start
    // of a 128-pixel literal that is left open across the next writes.
    send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
    send_byte(8'hFF); send_byte(8'h12); send_byte(8'h34); send_byte(8'h56);
    send_byte(8'h7F); send_byte(8'h01); send_byte(8'h02); send_byte(8'h03);

    // Raw mode with zero pixel size and zero image size; the index restarts.
    drain();
    write_config(1'b0, 3'd0, '0);
    send_byte(8'hAA); send_byte(8'h55);

    // Oversized pixel and image registers, then a pixel left half finished.
    drain();
    write_config(1'b0, 3'd7, MAX_PIXELS + 23'd1);
    send_byte(8'h01); send_byte(8'h02); send_byte(8'h03); send_byte(8'h04);
    send_byte(8'h11); send_byte(8'h22);

    // Smaller pixel size mid-pixel: the next byte completes it.
    drain();
    write_config(1'b0, 3'd2, MAX_PIXELS + 23'd1);
    send_byte(8'h33);

    // Back to run-length coding on a tiny image: the open literal is clamped,
    // then a run and a literal that both overrun the image end.
    drain();
    write_config(1'b1, 3'd1, 23'd3);
    send_byte(8'h44);
    send_byte(8'hC0); send_byte(8'h99);
    send_byte(8'h05); send_byte(8'hA1); send_byte(8'hA2); send_byte(8'hA3);

    // Random part in three idling phases, several register settings in each.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct <= 64;
        end
        1: begin
          tx_idle_pct = 64;
          rx_idle_pct <= 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int k = 0; k < 5; k++) begin
        drain();
        if (ph == 0 && k == 0) write_config(1'b1, 3'd4, MAX_PIXELS);
        else if (ph == 1 && k == 0) write_config(1'b1, 3'd1, 23'd1);
        else if (ph == 2 && k == 0) write_config(1'b0, 3'd1, 23'd50);
        else random_config();
        // The long hold-off comes while the sender offers every cycle.
        if (ph == 2 && k == 0) hold_req <= 1'b1;
        goal = bytes_sent + ITEMS_PER_SETTING;
        while (bytes_sent < goal) send_unit();
      end
    end

    drain();
    if (fail_count == 0 && fills_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
